// ===== sv/dnsr_pkg.sv =====
package dnsr_pkg;

    localparam int SampleW = 16;
    localparam int RandW   = 8;
    localparam int ByteW   = 8;
    localparam int ErrW    = 14;

    // Offset sum and error, wide enough for the sample, dither and carried error.
    localparam int SumW    = 18;
    localparam int ScaledW = SumW + 4;

    // x / 10 == (x * 52429) >> 19 holds exactly for 0 <= x <= 81919.
    localparam int MagW       = 17;
    localparam int RecipW     = 16;
    localparam int RecipShift = 19;
    localparam int ProdW      = MagW + RecipW;

    localparam logic [RecipW-1:0] Recip10  = RecipW'(52429);
    localparam logic [SumW-1:0]   Offset   = SumW'(32768);
    localparam logic [ByteW-1:0]  ByteMax  = '1;
    localparam logic [ByteW-1:0]  ByteMin  = '0;

    typedef logic signed [ErrW-1:0] t_err;

    typedef struct packed {
        logic signed [SampleW-1:0] sample;
        logic [RandW-1:0]          rand_a;
        logic [RandW-1:0]          rand_b;
    } t_in_item;

    typedef struct packed {
        logic [ByteW-1:0] out_byte;
        t_err             next_err;
    } t_quant_res;

endpackage

// ===== sv/dnsr_if.sv =====
interface dnsr_in_if;
    import dnsr_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SampleW-1:0] sample;
    logic [RandW-1:0]          rand_a;
    logic [RandW-1:0]          rand_b;

    modport source (output valid, output sample, output rand_a, output rand_b, input ready);
    modport sink   (input valid, input sample, input rand_a, input rand_b, output ready);
endinterface

interface dnsr_out_if;
    import dnsr_pkg::*;

    logic             valid;
    logic             ready;
    logic [ByteW-1:0] out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

// ===== sv/dither_noise_shaping_requantizer_unit.sv =====
// An accepted item is held in the input register, then moves into the result register once
// that is free or being read: two register stages (input register, result register).
// Throughput: one item per cycle unless the result stalls; the carried error updates per item.
// The input stays ready while a finished result waits, as long as the input register is free.
// Reset (synchronous, active low) empties both stages and clears the carried error to zero.
module dither_noise_shaping_requantizer_unit
    import dnsr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    dnsr_in_if.sink       i_in,
    dnsr_out_if.source    o_out
);

    logic             r_in_valid;
    logic             n_in_valid;
    t_in_item         r_in_item;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [ByteW-1:0] r_out_byte;
    t_err             r_err;
    logic             w_advance;
    logic             w_in_take;
    t_in_item         w_in_item;
    t_quant_res       w_res;

    assign w_advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;
    assign w_in_take = i_in.valid && i_in.ready;

    assign w_in_item.sample = i_in.sample;
    assign w_in_item.rand_a = i_in.rand_a;
    assign w_in_item.rand_b = i_in.rand_b;

    dnsr_quant u_quant (
        .i_item (r_in_item),
        .i_err  (r_err),
        .o_res  (w_res)
    );

    always_comb begin
        n_in_valid = w_in_take || (r_in_valid && !w_advance);
        n_out_valid = w_advance || (r_out_valid && !o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_err       <= '0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_advance) begin
                r_err <= w_res.next_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_item <= w_in_item;
        end
        if (w_advance) begin
            r_out_byte <= w_res.out_byte;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;

    a_err_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> $stable(r_err))
        else $error("carried error changed while the result was stalled");

    a_err_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err >= -t_err'(2295)) && (r_err <= t_err'(4590)))
        else $error("carried error left its reachable range");

    a_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_item)))
        else $error("pending item lost from the input register");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_in_valid && (r_err == '0)))
        else $error("reset did not empty the pipeline");

endmodule

// ===== sv/dnsr_quant.sv =====
module dnsr_quant
    import dnsr_pkg::*;
(
    input  t_in_item   i_item,
    input  t_err       i_err,
    output t_quant_res o_res
);

    logic signed [SumW-1:0]    w_offs;
    logic [ByteW-1:0]          w_byte;
    logic signed [SumW-1:0]    w_qerr;
    logic signed [ScaledW-1:0] w_scaled;
    logic                      w_neg;
    logic [ScaledW-1:0]        w_mag_full;
    logic [MagW-1:0]           w_mag;
    logic [ProdW-1:0]          w_prod;
    logic [ErrW-1:0]           w_quot;

    always_comb begin
        w_offs = SumW'(i_item.sample)
               + $signed({{(SumW-RandW){1'b0}}, i_item.rand_a})
               - $signed({{(SumW-RandW){1'b0}}, i_item.rand_b})
               + SumW'(i_err)
               + $signed(Offset);

        if (w_offs[SumW-1]) begin
            w_byte = ByteMin;
        end else if (|w_offs[SumW-2:SampleW]) begin
            w_byte = ByteMax;
        end else begin
            w_byte = w_offs[SampleW-1:SampleW-ByteW];
        end

        // The error is measured from the unclamped sum.
        w_qerr   = w_offs - $signed({{(SumW-SampleW){1'b0}}, w_byte, {(SampleW-ByteW){1'b0}}});
        w_scaled = (ScaledW'(w_qerr) <<< 3) + ScaledW'(w_qerr);

        // Divide the magnitude so that the quotient truncates toward zero.
        w_neg      = w_scaled[ScaledW-1];
        w_mag_full = w_neg ? ScaledW'(-w_scaled) : ScaledW'(w_scaled);
        w_mag      = w_mag_full[MagW-1:0];
        w_prod     = ProdW'(w_mag) * ProdW'(Recip10);
        w_quot     = w_prod[RecipShift+ErrW-1:RecipShift];

        o_res.out_byte = w_byte;
        o_res.next_err = w_neg ? t_err'(-w_quot) : t_err'(w_quot);
    end

endmodule

// ===== sim/dither_noise_shaping_requantizer_unit_test.sv =====
module dither_noise_shaping_requantizer_unit_test
    import dnsr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit   = 200000;
    localparam int PhaseCount   = 4;
    localparam int PhaseItems   = 335;
    localparam int SettleCycles = 8;
    localparam int MaxPrinted   = 20;

    localparam int SenderIdle[PhaseCount]   = '{0, 46, 0, 31};
    localparam int ReceiverStall[PhaseCount] = '{0, 0, 46, 31};

    logic i_clk;
    logic i_rst_n;

    dnsr_in_if  in_ch();
    dnsr_out_if out_ch();

    dither_noise_shaping_requantizer_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_in_item         pending_items[$];
    logic [ByteW-1:0] expected_bytes[$];

    t_err             shaped_err;
    int               idle_pct;
    int               stall_pct;
    int               cycle_count;
    int               mismatches;
    int               items_sent;
    int               results_seen;
    int               clamped_high;
    int               clamped_low;
    int               directed_count;
    int               last_sample;
    logic [ByteW-1:0] wanted_byte;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [ByteW-1:0] requantize(input t_in_item it);
        int total;
        int offs;
        int level;
        int qerr;
        total = int'(it.sample) + int'(it.rand_a) - int'(it.rand_b) + int'(shaped_err);
        offs  = total + 32768;
        if (offs < 0) begin
            offs = 0;
            clamped_low++;
        end
        if (offs > 65535) begin
            offs = 65535;
            clamped_high++;
        end
        level      = offs / 256;
        qerr       = total - (level * 256 - 32768);
        shaped_err = t_err'((qerr * 9) / 10);
        return ByteW'(level);
    endfunction

    function automatic t_in_item make_item(input int smp, input int ra, input int rb);
        t_in_item it;
        it.sample = SampleW'(smp);
        it.rand_a = RandW'(ra);
        it.rand_b = RandW'(rb);
        return it;
    endfunction

    function automatic t_in_item random_item();
        int smp;
        case ($urandom_range(9))
            6, 7: begin
                if ($urandom_range(1) == 1) begin
                    smp = 32767 - int'($urandom_range(400));
                end else begin
                    smp = -32768 + int'($urandom_range(400));
                end
            end
            8: smp = int'($urandom_range(1024)) - 512;
            9: smp = last_sample + int'($urandom_range(64)) - 32;
            default: smp = int'($signed(SampleW'($urandom)));
        endcase
        if (smp > 32767) smp = 32767;
        if (smp < -32768) smp = -32768;
        last_sample = smp;
        return make_item(smp, $urandom_range(255), $urandom_range(255));
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MaxPrinted) begin
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("dither_noise_shaping_requantizer_unit regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_bytes.push_back(requantize({in_ch.sample, in_ch.rand_a, in_ch.rand_b}));
                items_sent++;
            end
            if (in_ch.valid && !in_ch.ready) begin
                in_ch.valid <= 1'b1;
            end else if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
                t_in_item nxt;
                nxt = pending_items.pop_front();
                in_ch.valid  <= 1'b1;
                in_ch.sample <= nxt.sample;
                in_ch.rand_a <= nxt.rand_a;
                in_ch.rand_b <= nxt.rand_b;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                results_seen++;
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected item out_byte=0x%02h", out_ch.out_byte));
                end else begin
                    wanted_byte = expected_bytes.pop_front();
                    if (out_ch.out_byte !== wanted_byte) begin
                        report_mismatch($sformatf("out_byte=0x%02h, want 0x%02h",
                                                  out_ch.out_byte, wanted_byte));
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.sample = '0;
        in_ch.rand_a = '0;
        in_ch.rand_b = '0;
        out_ch.ready = 1'b0;
        shaped_err   = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        cycle_count  = 0;
        mismatches   = 0;
        items_sent   = 0;
        results_seen = 0;
        clamped_high = 0;
        clamped_low  = 0;
        last_sample  = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_items.push_back(make_item(0, 0, 0));
        pending_items.push_back(make_item(0, 255, 0));
        pending_items.push_back(make_item(0, 0, 255));
        pending_items.push_back(make_item(0, 255, 255));
        repeat (4) pending_items.push_back(make_item(32767, 255, 0));
        pending_items.push_back(make_item(32767, 0, 0));
        pending_items.push_back(make_item(-32767, 0, 255));
        repeat (3) pending_items.push_back(make_item(-32768, 0, 255));
        pending_items.push_back(make_item(-32768, 255, 0));
        pending_items.push_back(make_item(-32768, 0, 0));
        pending_items.push_back(make_item(1, 0, 0));
        pending_items.push_back(make_item(-1, 0, 0));
        pending_items.push_back(make_item(127, 128, 1));
        pending_items.push_back(make_item(-129, 1, 128));
        pending_items.push_back(make_item(21845, 170, 85));
        pending_items.push_back(make_item(-21846, 85, 170));
        pending_items.push_back(make_item(0, 128, 128));
        directed_count = pending_items.size();

        for (int p = 0; p < PhaseCount; p++) begin
            idle_pct  <= SenderIdle[p];
            stall_pct <= ReceiverStall[p];
            repeat (PhaseItems) pending_items.push_back(random_item());
            // Hold the sender back until the block has returned every result of this phase.
            while (pending_items.size() != 0 || in_ch.valid || expected_bytes.size() != 0) begin
                @(negedge i_clk);
            end
        end

        repeat (SettleCycles) @(posedge i_clk);

        $display("sent %0d items (%0d directed) under four sender idle and receiver stall mixes",
                 items_sent, directed_count);
        $display("checked %0d results, %0d clamped high, %0d clamped low, %0d mismatches",
                 results_seen, clamped_high, clamped_low, mismatches);
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("dither_noise_shaping_requantizer_unit regression: pass");
        end else begin
            $display("dither_noise_shaping_requantizer_unit regression: fail");
        end
        $finish;
    end

endmodule
